### rtl/core/vfd_pkg.sv
// ----------------------------------------------------------------------------
// vfd_pkg
// Shared types and constants for the frame deframer and loss counter.
// ----------------------------------------------------------------------------
package vfd_pkg;

  localparam logic [1:0]  ROUTE_NONE   = 2'd0;
  localparam logic [1:0]  ROUTE_STREAM = 2'd1;
  localparam logic [1:0]  ROUTE_TEXT   = 2'd2;

  localparam logic [15:0] SEQ_POS      = 16'd2;

  // Classified byte, passed from the front end to the counter stage
  typedef struct packed {
    logic       is_seq;
    logic       cnt;
    logic [1:0] route;
    logic       tend;
    logic [7:0] data;
  } vfd_op_t;

endpackage

### rtl/core/vfd_front.sv
// ----------------------------------------------------------------------------
// vfd_front
// Tracks the byte position within a frame, latches the header fields and
// classifies each byte into a routing/counting operation.
// ----------------------------------------------------------------------------
module vfd_front
  import vfd_pkg::*;
#(
  parameter int HEADER_BYTES  = 5,
  parameter int TRAILER_BYTES = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept,
  input  logic [7:0]  data_byte,
  input  logic [15:0] frame_length,
  output vfd_op_t     op
);

  localparam logic [15:0] HB  = 16'(HEADER_BYTES);
  localparam logic [15:0] HB1 = 16'(HEADER_BYTES + 1);
  localparam logic [15:0] HB2 = 16'(HEADER_BYTES + 2);
  localparam logic [15:0] HB3 = 16'(HEADER_BYTES + 3);
  localparam logic [15:0] TB  = 16'(TRAILER_BYTES);

  logic [15:0]        pos_r, pos_nxt;
  logic [15:0]        bl_r, bl_nxt;
  logic [1:0]         ver_r, ver_nxt;
  logic               voice_r, voice_nxt;
  logic [15:0]        tl_r, tl_nxt;
  logic [16:0]        pos_inc;
  logic [15:0]        offset;
  logic signed [17:0] split;
  logic signed [17:0] pos_s;

  assign pos_inc = {1'b0, pos_r} + 17'd1;
  assign offset  = pos_r - HB3;
  assign split   = $signed({2'b00, bl_r}) - $signed({2'b00, tl_r});
  assign pos_s   = $signed({2'b00, pos_r});

  always_comb begin
    pos_nxt   = pos_r;
    bl_nxt    = bl_r;
    ver_nxt   = ver_r;
    voice_nxt = voice_r;
    tl_nxt    = tl_r;
    op        = '0;
    op.data   = data_byte;
    if (accept) begin
      if (pos_r < HB) begin
        if (pos_r == 16'd0) begin
          bl_nxt = frame_length - TB;
        end
        if (pos_r == SEQ_POS) begin
          op.is_seq = 1'b1;
        end
      end else if (pos_r == HB) begin
        tl_nxt    = 16'd0;
        ver_nxt   = data_byte[1:0];
        voice_nxt = data_byte[2];
        op.cnt    = 1'b1;
      end else begin
        op.cnt = 1'b1;
        if (ver_r == 2'd0) begin
          if (pos_r == HB1) begin
            tl_nxt = tl_r | {8'h00, data_byte};
          end else if (pos_r == HB2) begin
            tl_nxt = tl_r | {data_byte, 8'h00};
          end else if (voice_r) begin
            if (pos_s < split) begin
              op.route = ROUTE_STREAM;
            end else begin
              op.route = ROUTE_TEXT;
              op.tend  = (pos_inc == {1'b0, bl_r});
            end
          end else if (tl_r != 16'd0) begin
            if (offset < tl_r) begin
              op.route = ROUTE_TEXT;
            end else if (offset == tl_r) begin
              op.tend = 1'b1;
            end
          end
        end
      end
      pos_nxt = (pos_inc >= {1'b0, bl_nxt}) ? 16'd0 : pos_inc[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      ver_r   <= '0;
      voice_r <= 1'b0;
      tl_r    <= '0;
    end else begin
      pos_r   <= pos_nxt;
      ver_r   <= ver_nxt;
      voice_r <= voice_nxt;
      tl_r    <= tl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bl_r <= bl_nxt;
  end

  a_tend_not_stream: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && op.tend) |-> (op.route != ROUTE_STREAM))
    else $error("text end flagged on a stream byte");

  a_seq_no_route: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && op.is_seq) |-> (op.route == ROUTE_NONE && !op.cnt))
    else $error("sequence byte also routed or counted");

endmodule

### rtl/core/vfd_queue.sv
// ----------------------------------------------------------------------------
// vfd_queue
// Short queue of classified operations between front end and counter stage.
// ----------------------------------------------------------------------------
module vfd_queue
  import vfd_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    wr_en,
  input  vfd_op_t wr_op,
  output logic    full,
  input  logic    rd_en,
  output vfd_op_t rd_op,
  output logic    rd_valid
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  vfd_op_t          mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full     = (count_r == CNT_FULL);
  assign rd_valid = (count_r != '0);
  assign rd_op    = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (wr_en && !rd_en) begin
      count_nxt = count_r + 1'b1;
    end else if (!wr_en && rd_en) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr_r] <= wr_op;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> !full)
    else $error("write into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> rd_valid)
    else $error("read from empty queue");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL)
    else $error("queue count out of range");

endmodule

### rtl/core/vfd_back.sv
// ----------------------------------------------------------------------------
// vfd_back
// Applies classified operations: sequence gap loss counting, payload byte
// count, and the result register.
// ----------------------------------------------------------------------------
module vfd_back
  import vfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  vfd_op_t     q_op,
  output logic        q_rd,
  output logic        out_valid,
  input  logic        out_take,
  output logic [1:0]  route,
  output logic [7:0]  obyte,
  output logic        text_end,
  output logic        counts_updated,
  output logic [31:0] lost_frames,
  output logic [31:0] total_frames,
  output logic [31:0] payload_byte_count
);

  logic        valid_r;
  logic [1:0]  route_r;
  logic [7:0]  byte_r;
  logic        tend_r;
  logic        upd_r, upd_nxt;
  logic [7:0]  last_r, last_nxt;
  logic        seen_r, seen_nxt;
  logic [31:0] lost_r, lost_nxt;
  logic [31:0] total_r, total_nxt;
  logic [31:0] cnt_r, cnt_nxt;
  logic [7:0]  gap;
  logic [8:0]  gap_p1;
  logic [32:0] lost_sum;
  logic [32:0] total_sum;
  logic [31:0] lost_sat;
  logic [31:0] total_sat;

  assign q_rd      = q_valid && (!valid_r || out_take);
  assign gap       = q_op.data - last_r - 8'd1;
  assign gap_p1    = {1'b0, gap} + 9'd1;
  assign lost_sum  = {1'b0, lost_r} + {25'd0, gap};
  assign total_sum = {1'b0, total_r} + {24'd0, gap_p1};
  assign lost_sat  = lost_sum[32] ? 32'hFFFF_FFFF : lost_sum[31:0];
  assign total_sat = total_sum[32] ? 32'hFFFF_FFFF : total_sum[31:0];

  always_comb begin
    last_nxt  = last_r;
    seen_nxt  = seen_r;
    lost_nxt  = lost_r;
    total_nxt = total_r;
    cnt_nxt   = cnt_r;
    upd_nxt   = 1'b0;
    if (q_rd) begin
      if (q_op.is_seq) begin
        if (seen_r) begin
          lost_nxt  = lost_sat;
          total_nxt = total_sat;
          upd_nxt   = (lost_sat != lost_r) || (total_sat != total_r);
        end
        seen_nxt = 1'b1;
        last_nxt = q_op.data;
      end
      if (q_op.cnt) begin
        cnt_nxt = cnt_r + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      last_r  <= '0;
      seen_r  <= 1'b0;
      lost_r  <= '0;
      total_r <= '0;
      cnt_r   <= '0;
    end else begin
      if (q_rd) begin
        valid_r <= 1'b1;
      end else if (out_take) begin
        valid_r <= 1'b0;
      end
      last_r  <= last_nxt;
      seen_r  <= seen_nxt;
      lost_r  <= lost_nxt;
      total_r <= total_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd) begin
      route_r <= q_op.route;
      byte_r  <= (q_op.route != ROUTE_NONE) ? q_op.data : 8'h00;
      tend_r  <= q_op.tend;
      upd_r   <= upd_nxt;
    end
  end

  assign out_valid          = valid_r;
  assign route              = route_r;
  assign obyte              = byte_r;
  assign text_end           = tend_r;
  assign counts_updated     = upd_r;
  assign lost_frames        = lost_r;
  assign total_frames       = total_r;
  assign payload_byte_count = cnt_r;

  a_lost_le_total: assert property (@(posedge clk) disable iff (!rst_n)
    lost_r <= total_r)
    else $error("lost frame count exceeds total");

  a_upd_total_nz: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && upd_r) |-> (total_r != 32'd0))
    else $error("counter update with zero total");

  a_idle_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && route_r == ROUTE_NONE) |-> (byte_r == 8'h00))
    else $error("unrouted result carries a byte");

endmodule

### rtl/core/vlc_frame_deframer_loss_counter.sv
// ----------------------------------------------------------------------------
// vlc_frame_deframer_loss_counter
// Frame deframer: routes body bytes to stream or text, counts lost frames
// from sequence gaps and counts payload bytes.
// ----------------------------------------------------------------------------
//  channel  | handshake          | payload
//  ---------+--------------------+----------------------------------------------
//  input    | push / full        | in_data_byte, in_frame_length
//  result   | pop / empty        | out_route, out_out_byte, out_text_end,
//           |                    | out_counts_updated, out_lost_frames,
//           |                    | out_total_frames, out_payload_byte_count
//
//  One result per byte, one byte per cycle sustained while pop keeps up.
//  Path from push to result: classified into the queue, then counted into the result register.
//  The 32-bit saturating adds in the counter stage set the cycle time.
//  Reset is synchronous; no clearing pass.
//  A stalled result side fills the queue and then raises full.
// ----------------------------------------------------------------------------
module vlc_frame_deframer_loss_counter
  import vfd_pkg::*;
#(
  parameter int HEADER_BYTES  = 5,
  parameter int TRAILER_BYTES = 2,
  parameter int QUEUE_DEPTH   = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_data_byte,
  input  logic [15:0] in_frame_length,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  out_route,
  output logic [7:0]  out_out_byte,
  output logic        out_text_end,
  output logic        out_counts_updated,
  output logic [31:0] out_lost_frames,
  output logic [31:0] out_total_frames,
  output logic [31:0] out_payload_byte_count
);

  logic    accept;
  logic    q_full;
  logic    q_rd;
  logic    q_valid;
  logic    res_valid;
  vfd_op_t front_op;
  vfd_op_t q_op;

  assign full   = q_full;
  assign accept = push && !q_full;
  assign empty  = !res_valid;

  vfd_front #(
    .HEADER_BYTES  (HEADER_BYTES),
    .TRAILER_BYTES (TRAILER_BYTES)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .data_byte    (in_data_byte),
    .frame_length (in_frame_length),
    .op           (front_op)
  );

  vfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (accept),
    .wr_op    (front_op),
    .full     (q_full),
    .rd_en    (q_rd),
    .rd_op    (q_op),
    .rd_valid (q_valid)
  );

  vfd_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_valid            (q_valid),
    .q_op               (q_op),
    .q_rd               (q_rd),
    .out_valid          (res_valid),
    .out_take           (pop),
    .route              (out_route),
    .obyte              (out_out_byte),
    .text_end           (out_text_end),
    .counts_updated     (out_counts_updated),
    .lost_frames        (out_lost_frames),
    .total_frames       (out_total_frames),
    .payload_byte_count (out_payload_byte_count)
  );

endmodule

### test/tb.sv
// ----------------------------------------------------------------------------
// tb: frame deframer and loss counter
// Sends frame bytes through the push/full queue, predicts each result from a
// cycle-free copy of the deframing and loss-counting rules, and compares every
// popped result field by field. Directed frames come first, then random
// frames, the first of them long, under several idling patterns and one long
// receiver hold-off that fills the block.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import vfd_pkg::*;

  localparam int HDR = 5;
  localparam int TRL = 2;

  typedef struct {
    logic [1:0]  route;
    logic [7:0]  obyte;
    logic        tend;
    logic        upd;
    logic [31:0] lost;
    logic [31:0] total;
    logic [31:0] bytes;
  } deframe_result_t;

  class frame_tracker;
    logic [15:0] pos = '0;
    logic [15:0] body_len = '0;
    logic [15:0] text_len = '0;
    logic [7:0]  last_seq = '0;
    bit          seq_seen = 0;
    logic [1:0]  version = '0;
    bit          voice = 0;
    logic [31:0] lost = '0;
    logic [31:0] total = '0;
    logic [31:0] byte_cnt = '0;
    deframe_result_t pending_results[$];
    int mismatches, checked, frames, stream_bytes, text_bytes, text_ends, loss_updates;

    function logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%0t mismatch: %s", $realtime, msg);
    endfunction

    function void take_byte(logic [7:0] b, logic [15:0] fl);
      deframe_result_t r;
      logic [7:0]  gap;
      logic [31:0] nl, nt;
      int nx, split, off;
      r.route = ROUTE_NONE;
      r.obyte = '0;
      r.tend  = 1'b0;
      r.upd   = 1'b0;
      if (pos < HDR) begin
        if (pos == 0) begin
          body_len = fl - 16'(TRL);
          frames++;
        end
        if (pos == SEQ_POS) begin
          if (seq_seen) begin
            gap = b - last_seq - 8'd1;
            nl = sat_add(lost, {24'd0, gap});
            nt = sat_add(total, {24'd0, gap} + 32'd1);
            r.upd = (nl != lost) || (nt != total);
            lost = nl;
            total = nt;
          end
          seq_seen = 1;
          last_seq = b;
        end
      end else if (pos == HDR) begin
        text_len = '0;
        version = b[1:0];
        voice = b[2];
        byte_cnt++;
      end else begin
        if (version == 2'd0) begin
          if (pos == HDR + 1) begin
            text_len = text_len | {8'd0, b};
          end else if (pos == HDR + 2) begin
            text_len = text_len | {b, 8'd0};
          end else if (voice) begin
            split = int'(body_len) - int'(text_len);
            r.obyte = b;
            if (int'(pos) < split) begin
              r.route = ROUTE_STREAM;
            end else begin
              r.route = ROUTE_TEXT;
              r.tend = (int'(pos) + 1 == int'(body_len));
            end
          end else if (text_len != 0) begin
            off = int'(pos) - (HDR + 3);
            if (off < int'(text_len)) begin
              r.route = ROUTE_TEXT;
              r.obyte = b;
            end else if (off == int'(text_len)) begin
              r.tend = 1'b1;
            end
          end
        end
        byte_cnt++;
      end
      nx = int'(pos) + 1;
      pos = (nx >= int'(body_len)) ? 16'd0 : 16'(nx);
      r.lost  = lost;
      r.total = total;
      r.bytes = byte_cnt;
      if (r.route == ROUTE_STREAM) stream_bytes++;
      if (r.route == ROUTE_TEXT) text_bytes++;
      if (r.tend) text_ends++;
      if (r.upd) loss_updates++;
      pending_results.push_back(r);
    endfunction

    function void match_result(deframe_result_t got);
      deframe_result_t e;
      if (pending_results.size() == 0) begin
        flag("result popped with nothing outstanding");
        return;
      end
      e = pending_results.pop_front();
      checked++;
      if (got.route !== e.route)
        flag($sformatf("result %0d route: expected %0d, got %0d", checked, e.route, got.route));
      if (got.obyte !== e.obyte)
        flag($sformatf("result %0d out_byte: expected %0h, got %0h", checked, e.obyte, got.obyte));
      if (got.tend !== e.tend)
        flag($sformatf("result %0d text_end: expected %0b, got %0b", checked, e.tend, got.tend));
      if (got.upd !== e.upd)
        flag($sformatf("result %0d counts_updated: expected %0b, got %0b",
                       checked, e.upd, got.upd));
      if (got.lost !== e.lost)
        flag($sformatf("result %0d lost_frames: expected %0h, got %0h", checked, e.lost, got.lost));
      if (got.total !== e.total)
        flag($sformatf("result %0d total_frames: expected %0h, got %0h",
                       checked, e.total, got.total));
      if (got.bytes !== e.bytes)
        flag($sformatf("result %0d payload_byte_count: expected %0h, got %0h",
                       checked, e.bytes, got.bytes));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        push;
  logic        full;
  logic [7:0]  in_data_byte;
  logic [15:0] in_frame_length;
  logic        empty;
  logic        pop;
  logic [1:0]  out_route;
  logic [7:0]  out_out_byte;
  logic        out_text_end;
  logic        out_counts_updated;
  logic [31:0] out_lost_frames;
  logic [31:0] out_total_frames;
  logic [31:0] out_payload_byte_count;

  frame_tracker    trk = new();
  deframe_result_t seen;
  int              send_idle_pct = 0;
  int              recv_stall_pct = 0;
  int              full_stalls = 0;
  bit              hold_req = 0;
  bit              holding = 0;
  logic [15:0]     text_plan = '0;

  vlc_frame_deframer_loss_counter dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .push                   (push),
    .full                   (full),
    .in_data_byte           (in_data_byte),
    .in_frame_length        (in_frame_length),
    .empty                  (empty),
    .pop                    (pop),
    .out_route              (out_route),
    .out_out_byte           (out_out_byte),
    .out_text_end           (out_text_end),
    .out_counts_updated     (out_counts_updated),
    .out_lost_frames        (out_lost_frames),
    .out_total_frames       (out_total_frames),
    .out_payload_byte_count (out_payload_byte_count)
  );

  always #5 clk = ~clk;

  function automatic bit roll(int pct);
    return $urandom_range(99) < pct;
  endfunction

  function automatic logic [15:0] any_len();
    return 16'($urandom_range(65535, 3));
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic [15:0] fl);
    @(negedge clk);
    while (roll(send_idle_pct)) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    in_data_byte <= b;
    in_frame_length <= fl;
    @(posedge clk);
    while (full) begin
      full_stalls++;
      @(posedge clk);
    end
    trk.take_byte(b, fl);
  endtask

  // Mostly well-formed frames with random content; some broken headers.
  task automatic send_random(input int n, input logic [15:0] force_len);
    logic [7:0]  b;
    logic [15:0] fl;
    int r;
    for (int i = 0; i < n; i++) begin
      fl = any_len();
      b = 8'($urandom);
      r = $urandom_range(99);
      case (int'(trk.pos))
        0: begin
          if (force_len != 0 && i == 0) fl = force_len;
          else if (r < 5) fl = 16'($urandom_range(9, 3));
          else if (r < 90) fl = 16'($urandom_range(40, 10));
          else fl = 16'($urandom_range(300, 41));
        end
        int'(SEQ_POS): begin
          if (r < 70) b = trk.last_seq + 8'd1;
          else if (r < 88) b = trk.last_seq + 8'($urandom_range(6, 2));
          else if (r < 93) b = trk.last_seq;
        end
        HDR: if (r < 80) b[1:0] = 2'b00;
        HDR + 1: begin
          if (r < 15) text_plan = '0;
          else if (r < 30) text_plan = 16'($urandom);
          else if (trk.body_len > 8) text_plan = 16'($urandom_range(trk.body_len - 8, 1));
          else text_plan = 16'($urandom_range(3));
          b = text_plan[7:0];
        end
        HDR + 2: b = text_plan[15:8];
        default: ;
      endcase
      send_byte(b, fl);
    end
  endtask

  initial begin
    pop = 1'b0;
    forever begin
      @(negedge clk);
      pop <= !(holding || roll(recv_stall_pct));
    end
  end

  always @(posedge clk) begin
    if (rst_n && pop && !empty) begin
      seen.route = out_route;
      seen.obyte = out_out_byte;
      seen.tend  = out_text_end;
      seen.upd   = out_counts_updated;
      seen.lost  = out_lost_frames;
      seen.total = out_total_frames;
      seen.bytes = out_payload_byte_count;
      trk.match_result(seen);
    end
  end

  // long receiver hold-off so the queue fills and full is raised
  initial begin
    wait (hold_req);
    holding = 1;
    repeat (300) @(posedge clk);
    holding = 0;
  end

  initial begin
    #(5_000_000);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    push = 1'b0;
    in_data_byte = '0;
    in_frame_length = '0;
    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // one-byte frames at the shortest length
    send_byte(8'hFF, 16'd3);
    send_byte(8'h00, 16'd3);
    // text frame, one text byte then the end mark; first sequence number
    send_byte(8'hA5, 16'd12);
    send_byte(8'h5A, 16'hFFFF);
    send_byte(8'h10, any_len());
    send_byte(8'h00, any_len());
    send_byte(8'hFF, any_len());
    send_byte(8'hF8, any_len());
    send_byte(8'h01, any_len());
    send_byte(8'h00, any_len());
    send_byte(8'h42, any_len());
    send_byte(8'h99, any_len());
    // voice frame: stream byte, then two text bytes; sequence goes backwards
    send_byte(8'h00, 16'd13);
    send_byte(8'h00, any_len());
    send_byte(8'h0F, any_len());
    send_byte(8'h00, any_len());
    send_byte(8'h00, any_len());
    send_byte(8'hFC, any_len());
    send_byte(8'h02, any_len());
    send_byte(8'h00, any_len());
    send_byte(8'h11, any_len());
    send_byte(8'h22, any_len());
    send_byte(8'h33, any_len());

    hold_req = 1;
    send_random(100, 16'd300);

    send_idle_pct = 77;
    send_random(90, '0);

    send_idle_pct = 0;
    recv_stall_pct = 77;
    send_random(90, '0);

    send_idle_pct = 33;
    recv_stall_pct = 33;
    send_random(90, '0);

    @(negedge clk);
    push <= 1'b0;
    recv_stall_pct = 0;
    for (int i = 0; i < 5000 && trk.pending_results.size() != 0; i++) @(posedge clk);
    repeat (10) @(posedge clk);
    if (trk.pending_results.size() != 0)
      trk.flag($sformatf("%0d results never arrived", trk.pending_results.size()));

    $display("Covered %0d bytes over %0d frame starts: %0d stream, %0d text, %0d message ends.",
             trk.checked, trk.frames, trk.stream_bytes, trk.text_bytes, trk.text_ends);
    $display("%0d loss updates (lost %0d of %0d); input held off by full for %0d cycles.",
             trk.loss_updates, trk.lost, trk.total, full_stalls);
    if (trk.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
